[sv/i2cmts_pkg.sv]
package i2cmts_pkg;

  localparam int TX_DEPTH = 16;
  localparam int RX_DEPTH = 16;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

  localparam logic [4:0] CNT_MAX = 5'd31;

  // Master status codes of the bus controller.
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RSTART     = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
  localparam logic [7:0] ST_DATW_ACK   = 8'h28;
  localparam logic [7:0] ST_DATW_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
  localparam logic [7:0] ST_DATR_ACK   = 8'h50;
  localparam logic [7:0] ST_DATR_NACK  = 8'h58;

  localparam logic [7:0] ADDR_MASK = 8'b11111110;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_STATUS  = 2'd2,
    FUNC_COLLECT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    LINK_IDLE   = 2'd0,
    LINK_BUSY   = 2'd1,
    LINK_FAILED = 2'd2,
    LINK_DATAV  = 2'd3
  } link_t;

  localparam logic [1:0] MODE_DUMMY = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] index;
    logic [7:0] byte_in;
    logic [6:0] target_addr;
    logic [1:0] mode;
    logic [4:0] tx_count;
    logic [4:0] rx_count;
    logic [7:0] status_code;
    logic       collect_last;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic       data_load;
    logic [7:0] data_out;
    logic       set_start;
    logic       set_stop;
    logic       set_ack;
    logic       clear_ack;
    logic [1:0] link_state;
    logic [7:0] read_byte;
    logic [6:0] read_addr;
  } out_word_t;

  typedef struct packed {
    logic             en;
    logic [TX_AW-1:0] addr;
    logic [7:0]       data;
  } tx_wr_t;

  typedef struct packed {
    logic             en;
    logic [RX_AW-1:0] addr;
    logic [7:0]       data;
  } rx_wr_t;

endpackage

[sv/i2cmts_tx_buf.sv]
module i2cmts_tx_buf (
  input  logic                      clk,
  input  i2cmts_pkg::tx_wr_t        wr,
  input  logic [i2cmts_pkg::TX_AW-1:0] rd_addr,
  output logic [7:0]                rd_data
);

  logic [7:0] store_r [i2cmts_pkg::TX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = store_r[rd_addr];

endmodule

[sv/i2cmts_rx_buf.sv]
module i2cmts_rx_buf (
  input  logic                      clk,
  input  logic                      rst_n,
  input  i2cmts_pkg::rx_wr_t        wr,
  input  logic [i2cmts_pkg::RX_AW-1:0] rd_addr,
  output logic [7:0]                rd_data
);

  logic [7:0] store_r [i2cmts_pkg::RX_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < i2cmts_pkg::RX_DEPTH; i++) begin
        store_r[i] <= 8'd0;
      end
    end else if (wr.en) begin
      store_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = store_r[rd_addr];

endmodule

[sv/i2cmts_ctrl.sv]
module i2cmts_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  i2cmts_pkg::in_word_t         word,
  output i2cmts_pkg::out_word_t        result,
  output i2cmts_pkg::tx_wr_t           tx_wr,
  output logic [i2cmts_pkg::TX_AW-1:0] tx_rd_addr,
  input  logic [7:0]                   tx_rd_data,
  output i2cmts_pkg::rx_wr_t           rx_wr,
  output logic [i2cmts_pkg::RX_AW-1:0] rx_rd_addr,
  input  logic [7:0]                   rx_rd_data
);

  logic [4:0]        cnt_r, cnt_nxt;
  i2cmts_pkg::link_t link_r, link_nxt;
  logic [7:0]        abyte_r, abyte_nxt;
  logic [4:0]        tx_total_r, tx_total_nxt;
  logic [4:0]        rx_total_r, rx_total_nxt;
  logic              dummy_r, dummy_nxt;
  logic [6:0]        saddr_r, saddr_nxt;

  logic [4:0] cnt_up;
  logic [4:0] tx_cnt_sel;
  logic       tx_idx_ok;
  logic       rx_idx_ok;
  logic [i2cmts_pkg::RX_AW-1:0] rx_pos;

  assign cnt_up = (cnt_r == i2cmts_pkg::CNT_MAX) ? cnt_r : cnt_r + 5'd1;

  // A data-ACK event advances the counter before the next byte is looked up.
  assign tx_cnt_sel = (word.status_code == i2cmts_pkg::ST_DATW_ACK) ? cnt_up : cnt_r;
  assign tx_rd_addr = (int'(tx_cnt_sel) >= i2cmts_pkg::TX_DEPTH) ?
                      i2cmts_pkg::TX_AW'(i2cmts_pkg::TX_DEPTH - 1) :
                      i2cmts_pkg::TX_AW'(tx_cnt_sel);
  assign rx_pos     = (int'(cnt_r) >= i2cmts_pkg::RX_DEPTH) ?
                      i2cmts_pkg::RX_AW'(i2cmts_pkg::RX_DEPTH - 1) :
                      i2cmts_pkg::RX_AW'(cnt_r);
  assign rx_rd_addr = i2cmts_pkg::RX_AW'(word.index);
  assign tx_idx_ok  = int'(word.index) < i2cmts_pkg::TX_DEPTH;
  assign rx_idx_ok  = int'(word.index) < i2cmts_pkg::RX_DEPTH;

  always_comb begin
    cnt_nxt      = cnt_r;
    link_nxt     = link_r;
    abyte_nxt    = abyte_r;
    tx_total_nxt = tx_total_r;
    rx_total_nxt = rx_total_r;
    dummy_nxt    = dummy_r;
    saddr_nxt    = saddr_r;
    result       = '0;
    tx_wr        = '0;
    rx_wr        = '0;
    case (i2cmts_pkg::func_t'(word.func))
      i2cmts_pkg::FUNC_LOAD: begin
        tx_wr.en   = take && tx_idx_ok;
        tx_wr.addr = i2cmts_pkg::TX_AW'(word.index);
        tx_wr.data = word.byte_in;
      end
      i2cmts_pkg::FUNC_START: begin
        if (link_r != i2cmts_pkg::LINK_BUSY) begin
          saddr_nxt    = word.target_addr;
          abyte_nxt    = ({1'b0, word.target_addr} << 1) & i2cmts_pkg::ADDR_MASK
                         | {7'd0, word.mode[0]};
          tx_total_nxt = word.tx_count;
          rx_total_nxt = word.rx_count;
          dummy_nxt    = (word.mode == i2cmts_pkg::MODE_DUMMY);
          link_nxt     = i2cmts_pkg::LINK_BUSY;
          result.set_start = 1'b1;
          result.accepted  = 1'b1;
        end
      end
      i2cmts_pkg::FUNC_STATUS: begin
        case (word.status_code) inside
          i2cmts_pkg::ST_START, i2cmts_pkg::ST_RSTART: begin
            result.data_load = 1'b1;
            result.data_out  = abyte_r;
          end
          i2cmts_pkg::ST_SLAW_ACK: begin
            result.data_load = 1'b1;
            result.data_out  = tx_rd_data;
          end
          i2cmts_pkg::ST_SLAW_NACK, i2cmts_pkg::ST_SLAR_NACK: begin
            result.set_stop = 1'b1;
            link_nxt        = i2cmts_pkg::LINK_FAILED;
            cnt_nxt         = 5'd0;
          end
          i2cmts_pkg::ST_DATW_ACK: begin
            if (cnt_up >= tx_total_r) begin
              if (dummy_r) begin
                result.set_start = 1'b1;
                abyte_nxt        = abyte_r | 8'd1;
              end else begin
                result.set_stop = 1'b1;
                link_nxt        = i2cmts_pkg::LINK_IDLE;
              end
              cnt_nxt = 5'd0;
            end else begin
              cnt_nxt          = cnt_up;
              result.data_load = 1'b1;
              result.data_out  = tx_rd_data;
            end
          end
          i2cmts_pkg::ST_DATW_NACK: begin
            result.set_stop = 1'b1;
            link_nxt        = i2cmts_pkg::LINK_IDLE;
            cnt_nxt         = 5'd0;
          end
          i2cmts_pkg::ST_ARB_LOST: begin
            cnt_nxt = 5'd0;
          end
          i2cmts_pkg::ST_SLAR_ACK: begin
            result.set_ack = 1'b1;
          end
          i2cmts_pkg::ST_DATR_ACK: begin
            rx_wr.en   = take;
            rx_wr.addr = rx_pos;
            rx_wr.data = word.byte_in;
            cnt_nxt    = cnt_up;
            // NACK the next byte once only the last one is still to come.
            if (({1'b0, cnt_up} + 6'd1) >= {1'b0, rx_total_r}) begin
              result.clear_ack = 1'b1;
            end else begin
              result.set_ack = 1'b1;
            end
          end
          i2cmts_pkg::ST_DATR_NACK: begin
            rx_wr.en        = take;
            rx_wr.addr      = rx_pos;
            rx_wr.data      = word.byte_in;
            result.set_stop = 1'b1;
            link_nxt        = i2cmts_pkg::LINK_DATAV;
            cnt_nxt         = 5'd0;
          end
          default: begin
          end
        endcase
      end
      i2cmts_pkg::FUNC_COLLECT: begin
        if (link_r == i2cmts_pkg::LINK_DATAV && rx_idx_ok) begin
          result.read_byte = rx_rd_data;
          rx_wr.en   = take;
          rx_wr.addr = i2cmts_pkg::RX_AW'(word.index);
          rx_wr.data = 8'd0;
        end
        result.read_addr = saddr_r;
        if (word.collect_last) begin
          link_nxt  = i2cmts_pkg::LINK_IDLE;
          saddr_nxt = 7'd0;
        end
      end
      default: begin
      end
    endcase
    result.link_state = link_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= 5'd0;
      link_r     <= i2cmts_pkg::LINK_IDLE;
      abyte_r    <= 8'd0;
      tx_total_r <= 5'd0;
      rx_total_r <= 5'd0;
      dummy_r    <= 1'b0;
      saddr_r    <= 7'd0;
    end else if (take) begin
      cnt_r      <= cnt_nxt;
      link_r     <= link_nxt;
      abyte_r    <= abyte_nxt;
      tx_total_r <= tx_total_nxt;
      rx_total_r <= rx_total_nxt;
      dummy_r    <= dummy_nxt;
      saddr_r    <= saddr_nxt;
    end
  end

endmodule

[sv/i2c_master_transaction_sequencer_unit.sv]
// I2C master transaction sequencer.
// The in_ channel carries one event word per transfer: load a transmit byte,
// start a transaction, report a bus controller status code, or collect a
// received byte. The out_ channel returns exactly one result word for every
// event: the byte to drive, the START/STOP/ACK commands, the link state and
// any collected byte with its transaction address.
// Both channels use valid/stall; a word moves on a clock edge where valid is
// high and stall is low. An event is decoded in the cycle it is accepted and
// its result is registered, so the result appears in the cycle after acceptance.
// One event per cycle is taken while the result register is free or being
// emptied in the same cycle; the single result register sets that rate.
// When the receiver stalls with a result pending, in_stall rises and the
// pending result holds until it is taken.
// Synchronous reset (rst_n low) empties the result register, sets the link
// idle, clears the counters, the address and the receive buffer. The
// transmit buffer is not cleared and must be loaded before it is sent.
module i2c_master_transaction_sequencer_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cmts_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cmts_pkg::out_word_t out_data
);

  logic                         take;
  logic                         out_valid_r, out_valid_nxt;
  i2cmts_pkg::out_word_t        out_data_r;
  i2cmts_pkg::out_word_t        result;
  i2cmts_pkg::tx_wr_t           tx_wr;
  i2cmts_pkg::rx_wr_t           rx_wr;
  logic [i2cmts_pkg::TX_AW-1:0] tx_rd_addr;
  logic [i2cmts_pkg::RX_AW-1:0] rx_rd_addr;
  logic [7:0]                   tx_rd_data;
  logic [7:0]                   rx_rd_data;

  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  i2cmts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .word       (in_data),
    .result     (result),
    .tx_wr      (tx_wr),
    .tx_rd_addr (tx_rd_addr),
    .tx_rd_data (tx_rd_data),
    .rx_wr      (rx_wr),
    .rx_rd_addr (rx_rd_addr),
    .rx_rd_data (rx_rd_data)
  );

  i2cmts_tx_buf u_tx_buf (
    .clk     (clk),
    .wr      (tx_wr),
    .rd_addr (tx_rd_addr),
    .rd_data (tx_rd_data)
  );

  i2cmts_rx_buf u_rx_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (rx_wr),
    .rd_addr (rx_rd_addr),
    .rd_data (rx_rd_data)
  );

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
